// ===== src/tpc_pkg.sv =====
// Shared types and constants of the triangle plane clipper.
package tpc_pkg;

    localparam int PLANE_W = 32;
    localparam int T_W     = 32;

    // Vertex sources for emission, positions relative to the rotated triangle.
    localparam logic [2:0] SRC_R0 = 3'd0;
    localparam logic [2:0] SRC_R1 = 3'd1;
    localparam logic [2:0] SRC_R2 = 3'd2;
    localparam logic [2:0] SRC_A  = 3'd3;
    localparam logic [2:0] SRC_B  = 3'd4;

    // Rotated vertex selectors for the interpolation endpoints.
    localparam logic [1:0] SEL_R0 = 2'd0;
    localparam logic [1:0] SEL_R1 = 2'd1;
    localparam logic [1:0] SEL_R2 = 2'd2;

    localparam logic [1:0] REG_PLANE_X = 2'd0;
    localparam logic [1:0] REG_PLANE_Y = 2'd1;
    localparam logic [1:0] REG_PLANE_Z = 2'd2;
    localparam logic [1:0] REG_PLANE_W = 2'd3;

    typedef struct packed {
        logic       load;
        logic [1:0] slot;
        logic       dist_en;
        logic [3:0] idx;
        logic       div_start;
        logic       div_step;
        logic [1:0] psel;
        logic [1:0] qsel;
        logic       int_en;
        logic       int_dst;
        logic       emit;
        logic [2:0] src;
        logic       closes;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic all_in;
        logic all_out;
        logic ins_r1;
        logic out_busy;
    } t_stat;

    function automatic logic [1:0] rot_idx(input logic [1:0] rot, input logic [1:0] k);
        logic [2:0] s;
        s = {1'b0, rot} + {1'b0, k};
        if (s >= 3'd3) begin
            s = s - 3'd3;
        end
        return s[1:0];
    endfunction

endpackage

// ===== src/tpc_ctrl.sv =====
// Controller sequencing load, distance, division, interpolation and emission.
module tpc_ctrl
    import tpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_DIST = 8'b00000010,
        S_DEC  = 8'b00000100,
        S_DIV0 = 8'b00001000,
        S_INT0 = 8'b00010000,
        S_DIV1 = 8'b00100000,
        S_INT1 = 8'b01000000,
        S_EMIT = 8'b10000000
    } t_state;

    localparam logic [1:0] MODE_ALL = 2'd0;
    localparam logic [1:0] MODE_TWO = 2'd1;
    localparam logic [1:0] MODE_ONE = 2'd2;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_vcnt, n_vcnt;
    logic [1:0] r_mode, n_mode;
    logic [2:0] w_src;
    logic       w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_vcnt  <= '0;
            r_mode  <= MODE_ALL;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_vcnt  <= n_vcnt;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        w_src = SRC_R0;
        case (r_mode)
            MODE_TWO: begin
                case (r_cnt[2:0])
                    3'd0, 3'd3: w_src = SRC_R0;
                    3'd1:       w_src = SRC_R1;
                    3'd2, 3'd4: w_src = SRC_B;
                    default:    w_src = SRC_A;
                endcase
            end
            MODE_ONE: begin
                case (r_cnt[2:0])
                    3'd0:    w_src = SRC_R0;
                    3'd1:    w_src = SRC_B;
                    default: w_src = SRC_A;
                endcase
            end
            default: begin
                case (r_cnt[2:0])
                    3'd0:    w_src = SRC_R0;
                    3'd1:    w_src = SRC_R1;
                    default: w_src = SRC_R2;
                endcase
            end
        endcase
        w_last = (r_mode == MODE_TWO) ? (r_cnt[2:0] == 3'd5) : (r_cnt[2:0] == 3'd2);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_vcnt  = r_vcnt;
        n_mode  = r_mode;
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.slot = r_vcnt;
                    if (r_vcnt == 2'd2) begin
                        n_vcnt  = '0;
                        n_cnt   = '0;
                        n_state = S_DIST;
                    end else begin
                        n_vcnt = r_vcnt + 2'd1;
                    end
                end
            end
            S_DIST: begin
                o_cmd.dist_en = (r_cnt < 6'd12);
                o_cmd.idx     = r_cnt[3:0];
                n_cnt         = r_cnt + 6'd1;
                if (r_cnt == 6'd12) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_cnt = '0;
                if (i_stat.all_in) begin
                    n_mode  = MODE_ALL;
                    n_state = S_EMIT;
                end else if (i_stat.all_out) begin
                    n_state = S_IDLE;
                end else begin
                    n_mode  = i_stat.ins_r1 ? MODE_TWO : MODE_ONE;
                    n_state = S_DIV0;
                end
            end
            S_DIV0, S_DIV1: begin
                o_cmd.div_start = (r_cnt == 6'd0);
                o_cmd.div_step  = (r_cnt != 6'd0);
                if (r_state == S_DIV0) begin
                    o_cmd.psel = SEL_R0;
                    o_cmd.qsel = SEL_R2;
                end else begin
                    o_cmd.psel = (r_mode == MODE_TWO) ? SEL_R1 : SEL_R0;
                    o_cmd.qsel = (r_mode == MODE_TWO) ? SEL_R2 : SEL_R1;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(T_W)) begin
                    n_cnt   = '0;
                    n_state = (r_state == S_DIV0) ? S_INT0 : S_INT1;
                end
            end
            S_INT0, S_INT1: begin
                o_cmd.int_en  = (r_cnt < 6'd4);
                o_cmd.idx     = r_cnt[3:0];
                o_cmd.int_dst = (r_state == S_INT1);
                n_cnt         = r_cnt + 6'd1;
                if (r_cnt == 6'd4) begin
                    n_cnt   = '0;
                    n_state = (r_state == S_INT0) ? S_DIV1 : S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.src    = w_src;
                    o_cmd.closes = (r_cnt[2:0] == 3'd2) || (r_cnt[2:0] == 3'd5);
                    o_cmd.last   = w_last;
                    n_cnt        = r_cnt + 6'd1;
                    if (w_last) begin
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== src/tpc_datapath.sv =====
// Datapath: vertex store, shared multiplier, distances, divider and output register.
module tpc_datapath
    import tpc_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_addr,
    input  logic [PLANE_W-1:0]            i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_pos_w,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic signed [COORD_WIDTH-1:0] o_out_w,
    output logic                          o_closes_triangle,
    output logic                          o_last
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + PLANE_W + 2;
    localparam int RW = DW + 2;

    logic signed [CW-1:0]      r_vtx [3][4];
    logic signed [PLANE_W-1:0] r_plane [4];
    logic signed [DW-1:0]      r_d [3];
    logic signed [CW-1:0]      r_a [4];
    logic signed [CW-1:0]      r_b [4];
    logic signed [DW-1:0]      r_prod;
    logic                      r_pv, r_iv, r_idst;
    logic [1:0]                r_pj, r_pi;
    logic [1:0]                r_ps, r_qs;
    logic [RW-1:0]             r_rem, r_den;
    logic [T_W-1:0]            r_t;
    logic                      r_valid;
    logic signed [CW-1:0]      r_ox, r_oy, r_oz, r_ow;
    logic                      r_oc, r_ol;

    logic [2:0]                w_ins;
    logic [1:0]                w_rot;
    logic signed [CW:0]        w_ma;
    logic signed [T_W:0]       w_mb;
    logic signed [DW-1:0]      w_prod;
    logic signed [DW:0]        w_den;
    logic [RW-1:0]             w_rs;
    logic signed [CW+1:0]      w_s;
    logic signed [CW+2:0]      w_sum;
    logic signed [CW-1:0]      w_sat;
    logic signed [CW-1:0]      w_ov [4];
    logic [1:0]                w_k;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_ins[j] = !r_d[j][DW-1];
        end
        if (w_ins[1] && !w_ins[0]) begin
            w_rot = 2'd1;
        end else if (w_ins[2] && !w_ins[1]) begin
            w_rot = 2'd2;
        end else begin
            w_rot = 2'd0;
        end
        o_stat.all_in   = &w_ins;
        o_stat.all_out  = ~|w_ins;
        o_stat.ins_r1   = w_ins[rot_idx(w_rot, SEL_R1)];
        o_stat.out_busy = r_valid && i_stall;
    end

    always_comb begin
        if (i_cmd.int_en) begin
            w_ma = (CW+1)'(r_vtx[r_qs][i_cmd.idx[1:0]]) - (CW+1)'(r_vtx[r_ps][i_cmd.idx[1:0]]);
            w_mb = {1'b0, r_t};
        end else begin
            w_ma = (CW+1)'(r_vtx[i_cmd.idx[3:2]][i_cmd.idx[1:0]]);
            w_mb = (T_W+1)'(r_plane[i_cmd.idx[1:0]]);
        end
        w_prod = DW'(w_ma * w_mb);
    end

    always_comb begin
        w_den = (DW+1)'(r_d[rot_idx(w_rot, i_cmd.psel)])
              - (DW+1)'(r_d[rot_idx(w_rot, i_cmd.qsel)]);
        w_rs  = {r_rem[RW-2:0], 1'b0};
        w_s   = r_prod[DW-1:T_W];
        w_sum = (CW+3)'(r_vtx[r_ps][r_pi]) + (CW+3)'(w_s);
        if (w_sum[CW+2:CW-1] == '0 || w_sum[CW+2:CW-1] == '1) begin
            w_sat = w_sum[CW-1:0];
        end else if (w_sum[CW+2]) begin
            w_sat = {1'b1, {(CW-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_ov[i] = r_a[i];
        end
        w_k = 2'd0;
        case (i_cmd.src)
            SRC_R0, SRC_R1, SRC_R2: begin
                w_k = rot_idx(w_rot, i_cmd.src[1:0]);
                for (int i = 0; i < 4; i++) begin
                    w_ov[i] = r_vtx[w_k][i];
                end
            end
            SRC_B: begin
                for (int i = 0; i < 4; i++) begin
                    w_ov[i] = r_b[i];
                end
            end
            default: begin
                for (int i = 0; i < 4; i++) begin
                    w_ov[i] = r_a[i];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane[0] <= PLANE_W'(1) << FRAC_BITS;
            r_plane[1] <= '0;
            r_plane[2] <= '0;
            r_plane[3] <= PLANE_W'(1) << FRAC_BITS;
            r_pv       <= 1'b0;
            r_iv       <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_PLANE_X: r_plane[0] <= i_cfg_data;
                    REG_PLANE_Y: r_plane[1] <= i_cfg_data;
                    REG_PLANE_Z: r_plane[2] <= i_cfg_data;
                    REG_PLANE_W: r_plane[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pv <= i_cmd.dist_en;
            r_iv <= i_cmd.int_en;
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vtx[i_cmd.slot][0] <= i_pos_x;
            r_vtx[i_cmd.slot][1] <= i_pos_y;
            r_vtx[i_cmd.slot][2] <= i_pos_z;
            r_vtx[i_cmd.slot][3] <= i_pos_w;
        end
        r_prod <= w_prod;
        r_pj   <= i_cmd.idx[3:2];
        r_pi   <= i_cmd.idx[1:0];
        r_idst <= i_cmd.int_dst;
        if (r_pv) begin
            r_d[r_pj] <= ((r_pi == 2'd0) ? '0 : r_d[r_pj]) + r_prod;
        end
        if (r_iv) begin
            if (r_idst) begin
                r_b[r_pi] <= w_sat;
            end else begin
                r_a[r_pi] <= w_sat;
            end
        end
        if (i_cmd.div_start) begin
            r_ps  <= rot_idx(w_rot, i_cmd.psel);
            r_qs  <= rot_idx(w_rot, i_cmd.qsel);
            r_rem <= RW'(r_d[rot_idx(w_rot, i_cmd.psel)]);
            r_den <= RW'(w_den);
            r_t   <= '0;
        end else if (i_cmd.div_step) begin
            if (w_rs >= r_den) begin
                r_rem <= w_rs - r_den;
                r_t   <= {r_t[T_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rs;
                r_t   <= {r_t[T_W-2:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            r_ox <= w_ov[0];
            r_oy <= w_ov[1];
            r_oz <= w_ov[2];
            r_ow <= w_ov[3];
            r_oc <= i_cmd.closes;
            r_ol <= i_cmd.last;
        end
    end

    assign o_valid           = r_valid;
    assign o_out_x           = r_ox;
    assign o_out_y           = r_oy;
    assign o_out_z           = r_oz;
    assign o_out_w           = r_ow;
    assign o_closes_triangle = r_oc;
    assign o_last            = r_ol;

endmodule

// ===== src/triangle_plane_clipper_top.sv =====
// Top level of the triangle plane clipper: controller plus datapath.
// The first two vertices of a triangle are only stored; the third is stored and followed by
// the plane distances and a decision, plus two divisions and two interpolations when clipped,
// then the emitted vertices, one per cycle while the output is not stalled.
// The input stalls while a triangle is processed.
// Synchronous active-low reset clears control state and restores the default plane.
module triangle_plane_clipper_top
    import tpc_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_pos_w,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_addr,
    input  logic [PLANE_W-1:0]            i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic signed [COORD_WIDTH-1:0] o_out_w,
    output logic                          o_closes_triangle,
    output logic                          o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    tpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    tpc_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .i_pos_w           (i_pos_w),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_out_x           (o_out_x),
        .o_out_y           (o_out_y),
        .o_out_z           (o_out_z),
        .o_out_w           (o_out_w),
        .o_closes_triangle (o_closes_triangle),
        .o_last            (o_last)
    );

endmodule

// ===== tb/triangle_plane_clipper_chk.sv =====
// Checker of the triangle plane clipper: watches both channels, predicts and compares vertices.
module triangle_plane_clipper_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_pos_w,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_out_x,
    input  logic [31:0] o_out_y,
    input  logic [31:0] o_out_z,
    input  logic [31:0] o_out_w,
    input  logic        o_closes_triangle,
    input  logic        o_last,
    output int          o_errors,
    output int          o_pending
);
    import tpc_pkg::*;

    typedef logic [3:0][31:0] vec_t;
    typedef logic signed [71:0] dist_t;

    typedef struct packed {
        vec_t pos;
        logic closes;
        logic last;
    } vtx_out_t;

    vtx_out_t   exp_vtx_q[$];
    vec_t       plane;
    vec_t       held [2];
    logic [1:0] held_cnt;
    int         errors;

    assign o_errors  = errors;
    assign o_pending = exp_vtx_q.size();

    function automatic dist_t plane_dist(vec_t v, vec_t pl);
        dist_t d;
        d = 0;
        for (int i = 0; i < 4; i++) begin
            d += $signed(v[i]) * $signed(pl[i]);
        end
        return d;
    endfunction

    function automatic logic [31:0] cross_frac(dist_t din, dist_t dout);
        logic [127:0] num;
        logic [127:0] den;
        num = 128'(din) << 32;
        den = 128'(din - dout);
        num = num / den;
        return num[31:0];
    endfunction

    function automatic vec_t lerp_sat(vec_t p, vec_t q, logic [31:0] t);
        vec_t r;
        logic signed [71:0] diff;
        logic signed [71:0] prod;
        logic signed [71:0] v;
        for (int i = 0; i < 4; i++) begin
            diff = $signed(q[i]) - $signed(p[i]);
            prod = diff * $signed({1'b0, t});
            v = $signed(p[i]) + (prod >>> 32);
            if (v > 72'sh7fffffff) begin
                r[i] = 32'h7fffffff;
            end else if (v < -72'sh80000000) begin
                r[i] = 32'h80000000;
            end else begin
                r[i] = v[31:0];
            end
        end
        return r;
    endfunction

    task automatic push_tri(vec_t a, vec_t b, vec_t c, logic fin);
        vtx_out_t e0, e1, e2;
        e0 = '{pos: a, closes: 1'b0, last: 1'b0};
        e1 = '{pos: b, closes: 1'b0, last: 1'b0};
        e2 = '{pos: c, closes: 1'b1, last: fin};
        exp_vtx_q = {exp_vtx_q, e0, e1, e2};
    endtask

    task automatic clip_triangle(vec_t v0, vec_t v1, vec_t v2);
        vec_t  v [3];
        dist_t d [3];
        logic  ins [3];
        int    r0, r1, r2;
        vec_t  a, b;
        v[0] = v0;
        v[1] = v1;
        v[2] = v2;
        for (int i = 0; i < 3; i++) begin
            d[i]   = plane_dist(v[i], plane);
            ins[i] = (d[i] >= 0);
        end
        if (ins[0] && ins[1] && ins[2]) begin
            push_tri(v[0], v[1], v[2], 1'b1);
        end else if (ins[0] || ins[1] || ins[2]) begin
            if (ins[1] && !ins[0]) begin
                r0 = 1; r1 = 2; r2 = 0;
            end else if (ins[2] && !ins[1]) begin
                r0 = 2; r1 = 0; r2 = 1;
            end else begin
                r0 = 0; r1 = 1; r2 = 2;
            end
            a = lerp_sat(v[r0], v[r2], cross_frac(d[r0], d[r2]));
            if (ins[r1]) begin
                b = lerp_sat(v[r1], v[r2], cross_frac(d[r1], d[r2]));
                push_tri(v[r0], v[r1], b, 1'b0);
                push_tri(v[r0], b, a, 1'b1);
            end else begin
                b = lerp_sat(v[r0], v[r1], cross_frac(d[r0], d[r1]));
                push_tri(v[r0], b, a, 1'b1);
            end
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    // Both channels are sampled mid-cycle, where inputs and outputs are stable.
    always @(negedge i_clk) begin
        vtx_out_t e;
        vec_t     in_pos;
        if (!i_rst_n) begin
            plane    <= {32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000};
            held_cnt <= 2'd0;
            errors    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_PLANE_X: plane[0] <= i_cfg_data;
                    REG_PLANE_Y: plane[1] <= i_cfg_data;
                    REG_PLANE_Z: plane[2] <= i_cfg_data;
                    REG_PLANE_W: plane[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                in_pos = {i_pos_w, i_pos_z, i_pos_y, i_pos_x};
                if (held_cnt < 2'd2) begin
                    held[held_cnt] = in_pos;
                    held_cnt <= held_cnt + 2'd1;
                end else begin
                    clip_triangle(held[0], held[1], in_pos);
                    held_cnt <= 2'd0;
                end
            end
            if (o_valid && !i_stall) begin
                if (exp_vtx_q.size() == 0) begin
                    report("unexpected vertex out_x", o_out_x, 32'h0);
                end else begin
                    e = exp_vtx_q.pop_front();
                    if (o_out_x !== e.pos[0]) report("out_x", o_out_x, e.pos[0]);
                    if (o_out_y !== e.pos[1]) report("out_y", o_out_y, e.pos[1]);
                    if (o_out_z !== e.pos[2]) report("out_z", o_out_z, e.pos[2]);
                    if (o_out_w !== e.pos[3]) report("out_w", o_out_w, e.pos[3]);
                    if (o_closes_triangle !== e.closes) begin
                        report("closes_triangle", 32'(o_closes_triangle), 32'(e.closes));
                    end
                    if (o_last !== e.last) report("last", 32'(o_last), 32'(e.last));
                end
            end
        end
    end

endmodule

// ===== tb/triangle_plane_clipper_top_tb.sv =====
// Testbench top of the triangle plane clipper: clock, reset, stimulus and verdict.
module triangle_plane_clipper_top_tb;
    import tpc_pkg::*;

    localparam int          CYCLE_LIMIT = 600000;
    localparam int          SETTLE      = 120;
    localparam logic [31:0] ONE         = 32'h0001_0000;
    localparam logic [31:0] MAXV        = 32'h7fffffff;
    localparam logic [31:0] MINV        = 32'h80000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_pos_x, i_pos_y, i_pos_z, i_pos_w;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_out_x, o_out_y, o_out_z, o_out_w;
    logic        o_closes_triangle;
    logic        o_last;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          gap_pct;
    int          stall_pct;

    triangle_plane_clipper_top u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_pos_x, .i_pos_y, .i_pos_z, .i_pos_w,
        .i_cfg_we, .i_cfg_addr, .i_cfg_data,
        .o_valid, .i_stall,
        .o_out_x, .o_out_y, .o_out_z, .o_out_w,
        .o_closes_triangle, .o_last
    );

    triangle_plane_clipper_chk u_chk (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_pos_x, .i_pos_y, .i_pos_z, .i_pos_w,
        .i_cfg_we, .i_cfg_addr, .i_cfg_data,
        .o_valid, .i_stall,
        .o_out_x, .o_out_y, .o_out_z, .o_out_w,
        .o_closes_triangle, .o_last,
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            return $urandom;
        end else if (sel == 1) begin
            return $urandom_range(1) ? MAXV : MINV;
        end else begin
            return 32'($urandom_range(32'h80000)) - 32'h40000;
        end
    endfunction

    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] w);
        logic taken;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_pos_z <= z;
        i_pos_w <= w;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_plane(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] pw);
        logic [31:0] vals [4];
        vals = '{px, py, pz, pw};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= 2'(r);
            i_cfg_data <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [31:0] pl [4];
        gap_pct    = 18;
        stall_pct  = 54;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_pos_x    = '0;
        i_pos_y    = '0;
        i_pos_z    = '0;
        i_pos_w    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = REG_PLANE_X;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default plane keeps x + w >= 0.
        send_vertex(0, 0, 0, ONE);              send_vertex(ONE, ONE, 0, ONE);
        send_vertex(-ONE, 0, ONE, ONE);
        send_vertex(-2 * ONE, 0, 0, ONE);       send_vertex(-3 * ONE, ONE, 0, ONE);
        send_vertex(-2 * ONE, 5, 7, ONE);
        send_vertex(ONE, 3, 0, ONE);            send_vertex(-3 * ONE, 0, ONE, ONE);
        send_vertex(-2 * ONE, ONE, 0, ONE);
        send_vertex(-3 * ONE, 0, 0, ONE);       send_vertex(0, ONE, ONE, ONE);
        send_vertex(-4 * ONE, 9, 0, ONE);
        send_vertex(-3 * ONE, 0, 0, ONE);       send_vertex(-5 * ONE, 2, 0, ONE);
        send_vertex(2 * ONE, ONE, 3, ONE);
        send_vertex(ONE, 0, 0, ONE);            send_vertex(0, ONE, 0, ONE);
        send_vertex(-7 * ONE, 3, 11, ONE);
        // A vertex exactly on the plane counts as inside.
        send_vertex(-ONE, 0, 0, ONE);           send_vertex(-2 * ONE, 0, 0, ONE);
        send_vertex(-3 * ONE, 0, 0, ONE);
        // Extreme coordinates drive the crossing points into saturation.
        send_vertex(MAXV, MAXV, MINV, 0);       send_vertex(MINV, MINV, MAXV, MINV);
        send_vertex(MAXV, MINV, MAXV, MAXV);
        wait_drained();

        for (int ph = 1; ph <= 8; ph++) begin
            if (ph == 4) begin
                gap_pct   = 54;
                stall_pct = 18;
            end else if (ph == 7) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            for (int r = 0; r < 4; r++) begin
                if (ph == 1) begin
                    pl[r] = r[0] ? MINV : MAXV;
                end else if (ph == 2) begin
                    pl[r] = (r == 3) ? ONE : '0;
                end else if (ph == 3) begin
                    pl[r] = r[0] ? MAXV : MINV;
                end else if (ph == 8) begin
                    pl[r] = '0;
                end else if ($urandom_range(4) == 0) begin
                    pl[r] = $urandom;
                end else begin
                    pl[r] = 32'($urandom_range(32'h40000)) - 32'h20000;
                end
            end
            set_plane(pl[0], pl[1], pl[2], pl[3]);
            for (int n = 0; n < 60; n++) begin
                send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end
            wait_drained();
        end

        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
